// ===== hw/rtl/bip_pkg.sv =====
package bip_pkg;

   localparam int ByteWidth    = 8;
   localparam int OpcodeWidth  = 7;
   localparam int OperandWidth = 32;
   localparam int LaneWidth    = 2;
   localparam int LimitWidth   = 8;
   localparam int CsrIdxWidth  = 1;

   localparam logic [ByteWidth-1:0]  END_HEADER      = 8'hFF;
   localparam logic [LimitWidth-1:0] UNARY_LIMIT_RST  = 8'd2;
   localparam logic [LimitWidth-1:0] BINARY_LIMIT_RST = 8'd20;
   localparam logic [LaneWidth-1:0]  LAST_LANE        = 2'd3;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_UNARY_LIMIT  = 1'b0,
      CSR_BINARY_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                    is_end;
      logic [OpcodeWidth-1:0]  opcode;
      logic                    binary_op;
      logic [OperandWidth-1:0] operand_a;
      logic [OperandWidth-1:0] operand_b;
   } result_type;

   typedef struct packed {
      logic [LimitWidth-1:0] unary_limit;
      logic [LimitWidth-1:0] binary_limit;
   } limits_type;

endpackage

// ===== hw/rtl/bip_in_stage.sv =====
module bip_in_stage
   import bip_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ByteWidth-1:0] req_data_byte,
   input  logic                 advance,
   output logic                 word_valid,
   output logic [ByteWidth-1:0] word_byte
);

   logic                 valid_ff, valid_in;
   logic [ByteWidth-1:0] byte_ff, byte_in;
   logic                 take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = take || (valid_ff && !advance);
      byte_in  = take ? req_data_byte : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign word_valid = valid_ff;
   assign word_byte  = byte_ff;

endmodule

// ===== hw/rtl/bip_decoder.sv =====
module bip_decoder
   import bip_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [ByteWidth-1:0] data_byte,
   input  limits_type           limits,
   output logic                 emit,
   output result_type           result
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_OPA    = 2'd1,
      PH_OPB    = 2'd2
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [LaneWidth-1:0]     byte_index_ff, byte_index_in;
   logic [ByteWidth-1:0]     header_ff, header_in;
   logic [OperandWidth-1:0]  operand_a_ff, operand_a_in;
   logic [OperandWidth-1:0]  operand_b_ff, operand_b_in;
   logic [OperandWidth-1:0]  lane_a, lane_b;
   logic                     hdr_binary;
   logic [LimitWidth-1:0]    hdr_opcode;
   logic                     hdr_ok;

   always_comb begin
      lane_a = operand_a_ff;
      lane_a[{byte_index_ff, 3'b000} +: ByteWidth] = data_byte;
      lane_b = operand_b_ff;
      lane_b[{byte_index_ff, 3'b000} +: ByteWidth] = data_byte;
      hdr_binary = data_byte[ByteWidth-1];
      hdr_opcode = {1'b0, data_byte[OpcodeWidth-1:0]};
      hdr_ok = hdr_binary ? (hdr_opcode < limits.binary_limit)
                          : (hdr_opcode < limits.unary_limit);
   end

   always_comb begin
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      header_in     = header_ff;
      operand_a_in  = operand_a_ff;
      operand_b_in  = operand_b_ff;
      emit          = 1'b0;
      result        = '0;
      if (step) begin
         unique case (phase_ff)
            PH_OPA: begin
               operand_a_in  = lane_a;
               byte_index_in = byte_index_ff + 2'd1;
               if (byte_index_ff == LAST_LANE) begin
                  if (header_ff[ByteWidth-1]) begin
                     phase_in = PH_OPB;
                  end else begin
                     phase_in         = PH_HEADER;
                     emit             = 1'b1;
                     result.opcode    = header_ff[OpcodeWidth-1:0];
                     result.operand_a = lane_a;
                  end
               end
            end
            PH_OPB: begin
               operand_b_in  = lane_b;
               byte_index_in = byte_index_ff + 2'd1;
               if (byte_index_ff == LAST_LANE) begin
                  phase_in         = PH_HEADER;
                  emit             = 1'b1;
                  result.opcode    = header_ff[OpcodeWidth-1:0];
                  result.binary_op = 1'b1;
                  result.operand_a = operand_a_ff;
                  result.operand_b = lane_b;
               end
            end
            default: begin
               phase_in      = PH_HEADER;
               byte_index_in = '0;
               if (data_byte == END_HEADER) begin
                  emit          = 1'b1;
                  result.is_end = 1'b1;
               end else if (hdr_ok) begin
                  header_in    = data_byte;
                  operand_a_in = '0;
                  operand_b_in = '0;
                  phase_in     = PH_OPA;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         byte_index_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
      end
      header_ff    <= header_in;
      operand_a_ff <= operand_a_in;
      operand_b_ff <= operand_b_in;
   end

`ifndef SYNTHESIS
   a_operand_emit_on_last_lane: assert property (@(posedge clock) disable iff (reset)
      emit && !result.is_end |-> byte_index_ff == LAST_LANE)
      else $error("instruction given before its last operand byte");

   a_end_marker_clean: assert property (@(posedge clock) disable iff (reset)
      emit && result.is_end |-> result.opcode == '0 && result.operand_a == '0
                                && result.operand_b == '0 && !result.binary_op)
      else $error("end marker carries instruction fields");

   a_reset_to_header: assert property (@(posedge clock)
      reset |=> phase_ff == PH_HEADER && byte_index_ff == '0)
      else $error("parser not awaiting header after reset");

   a_binary_from_opb: assert property (@(posedge clock) disable iff (reset)
      emit && result.binary_op |-> phase_ff == PH_OPB)
      else $error("binary instruction given outside second operand");
`endif

endmodule

// ===== hw/rtl/bip_out_stage.sv =====
module bip_out_stage
   import bip_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  result_type              result,
   output logic                    busy,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_is_end,
   output logic [OpcodeWidth-1:0]  rsp_opcode,
   output logic                    rsp_binary_op,
   output logic [OperandWidth-1:0] rsp_operand_a,
   output logic [OperandWidth-1:0] rsp_operand_b
);

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   assign busy = valid_ff && rsp_stall;

   always_comb begin
      valid_in  = load || busy;
      result_in = load ? result : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_is_end    = result_ff.is_end;
   assign rsp_opcode    = result_ff.opcode;
   assign rsp_binary_op = result_ff.binary_op;
   assign rsp_operand_a = result_ff.operand_a;
   assign rsp_operand_b = result_ff.operand_b;

endmodule

// ===== hw/rtl/bytecode_instruction_parser.sv =====
// channel | direction | words                   | handshake
// req     | in        | data_byte (8)           | req_valid / req_stall
// rsp     | out       | instruction (73)        | rsp_valid / rsp_stall
// csr     | in        | limit registers (8)     | csr_write_enable, no wait
//
// one byte per cycle while no result is stalled; an accepted byte reaches result valid through
// the input register, then decode into the result register
// a result is registered once its last operand byte or the end marker is decoded
// synchronous reset clears the parser to awaiting header, limits to 2 and 20
// a stalled result holds the input register; one more byte is taken meanwhile if it was empty
module bytecode_instruction_parser
   import bip_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [ByteWidth-1:0]    req_data_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_is_end,
   output logic [OpcodeWidth-1:0]  rsp_opcode,
   output logic                    rsp_binary_op,
   output logic [OperandWidth-1:0] rsp_operand_a,
   output logic [OperandWidth-1:0] rsp_operand_b,
   input  logic                    csr_write_enable,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [LimitWidth-1:0]   csr_write_data
);

   limits_type           limits_ff, limits_in;
   logic                 word_valid;
   logic [ByteWidth-1:0] word_byte;
   logic                 out_busy;
   logic                 advance;
   logic                 emit;
   result_type           result;

   always_comb begin
      limits_in = limits_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_UNARY_LIMIT:  limits_in.unary_limit  = csr_write_data;
            CSR_BINARY_LIMIT: limits_in.binary_limit = csr_write_data;
            default:          limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.unary_limit  <= UNARY_LIMIT_RST;
         limits_ff.binary_limit <= BINARY_LIMIT_RST;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign advance = !out_busy;

   bip_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .word_valid    (word_valid),
      .word_byte     (word_byte)
   );

   bip_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .step      (word_valid && advance),
      .data_byte (word_byte),
      .limits    (limits_ff),
      .emit      (emit),
      .result    (result)
   );

   bip_out_stage u_out_stage (
      .clock         (clock),
      .reset         (reset),
      .load          (emit),
      .result        (result),
      .busy          (out_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_end    (rsp_is_end),
      .rsp_opcode    (rsp_opcode),
      .rsp_binary_op (rsp_binary_op),
      .rsp_operand_a (rsp_operand_a),
      .rsp_operand_b (rsp_operand_b)
   );

endmodule
